// File: design/rbsi_pkg.sv
// Shared constants of the ray/box slab intersection block.
package rbsi_pkg;

  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

endpackage

// File: design/ray_box_slab_intersect.sv
// Top level of the ray/box slab intersection block.
// Channel | Dir | Contents
// s_axis  | in  | tdata: origin_x,y,z, dir_x,y,z, t_near, t_far (lowest first)
// m_axis  | out | tdata: hit, distance, zero pad to whole bytes
// cfg     | in  | box_min_x,y,z, box_max_x,y,z at indexes 0 to 5
// One ray a cycle while s_axis_tready is high; a ray passes the divider stages,
// the queue, four back stages and the output register before it leaves on m_axis.
// The front advances while the queue has room; the back advances when its output
// register is empty or being taken. A held result freezes the back, the queue
// fills, and s_axis_tready then falls. Reset clears all valid flags.
module ray_box_slab_intersect #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_near, t_far
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // hit, distance, zero pad
  output logic [((COORD_BITS+8)/8)*8-1:0] m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic [rbsi_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i
);
  import rbsi_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned OW = ((W + 8) / 8) * 8;
  localparam int unsigned QW = 11 * W;

  logic [W-1:0] bmin_q[3], bmax_q[3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        bmin_q[i] <= '0;
        bmax_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_X: bmin_q[0] <= cfg_data_i;
        REG_MIN_Y: bmin_q[1] <= cfg_data_i;
        REG_MIN_Z: bmin_q[2] <= cfg_data_i;
        REG_MAX_X: bmax_q[0] <= cfg_data_i;
        REG_MAX_Y: bmax_q[1] <= cfg_data_i;
        REG_MAX_Z: bmax_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [W-1:0] org[3], dir[3];
  for (genvar a = 0; a < 3; a++) begin : g_in
    assign org[a] = s_axis_tdata[a*W +: W];
    assign dir[a] = s_axis_tdata[(a+3)*W +: W];
  end

  logic          ov_q;
  logic [W:0]    od_q;
  logic          en_f, en_b, fv, q_push, q_pop, q_vld, q_room, bv, bhit;
  logic [QW-1:0] q_wdata, q_rdata;
  logic [W-1:0]  fdmin[3], fdmax[3], frcp[3], ftn, ftf;
  logic [W-1:0]  qdmin[3], qdmax[3], qrcp[3], qtn, qtf, bdist;

  // The front moves while the queue can take its last stage.
  assign en_f = q_room;
  assign s_axis_tready = en_f;
  assign q_push = fv && en_f;

  // The back moves whenever its output register is empty or being taken.
  assign en_b  = !ov_q || m_axis_tready;
  assign q_pop = q_vld && en_b;

  rbsi_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en_f), .vld_i(s_axis_tvalid && en_f),
    .box_min_i(bmin_q), .box_max_i(bmax_q), .org_i(org), .dir_i(dir),
    .tn_i(s_axis_tdata[6*W +: W]), .tf_i(s_axis_tdata[7*W +: W]),
    .vld_o(fv), .dmin_o(fdmin), .dmax_o(fdmax), .rcp_o(frcp),
    .tn_o(ftn), .tf_o(ftf)
  );

  assign q_wdata = {ftf, ftn, frcp[2], frcp[1], frcp[0], fdmax[2], fdmax[1], fdmax[0],
                    fdmin[2], fdmin[1], fdmin[0]};

  rbsi_queue #(.DW(QW), .DEPTH(4)) u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_wdata), .pop_i(q_pop),
    .valid_o(q_vld), .data_o(q_rdata), .room_o(q_room)
  );

  for (genvar a = 0; a < 3; a++) begin : g_q
    assign qdmin[a] = q_rdata[a*W +: W];
    assign qdmax[a] = q_rdata[(a+3)*W +: W];
    assign qrcp[a]  = q_rdata[(a+6)*W +: W];
  end
  assign qtn = q_rdata[9*W +: W];
  assign qtf = q_rdata[10*W +: W];

  rbsi_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en_b), .vld_i(q_vld),
    .dmin_i(qdmin), .dmax_i(qdmax), .rcp_i(qrcp), .tn_i(qtn), .tf_i(qtf),
    .vld_o(bv), .hit_o(bhit), .dist_o(bdist)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_b) begin
      ov_q <= bv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) od_q <= {bdist, bhit};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OW'(od_q);

endmodule

// File: design/rbsi_sdiv.sv
// Pipelined restoring divider forming the direction reciprocals, one bit a stage.
module rbsi_sdiv #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16,
  parameter int unsigned TAGW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [W-1:0]    d_i,
  input  logic [TAGW-1:0] tag_i,
  output logic [W-1:0]    r_o,
  output logic [TAGW-1:0] tag_o
);
  import rbsi_pkg::*;

  localparam int unsigned N  = 2 * F + 1;
  localparam int unsigned RW = W + 1;

  logic [W-1:0]    dm_q  [N+1];
  logic            neg_q [N+1];
  logic            zero_q[N+1];
  logic [RW-1:0]   rem_q [N+1];
  logic [N-1:0]    quo_q [N+1];
  logic [TAGW-1:0] tag_q [N+1];

  always_comb begin
    dm_q[0]   = d_i[W-1] ? (~d_i + 1'b1) : d_i;
    neg_q[0]  = d_i[W-1];
    zero_q[0] = (d_i == '0);
    rem_q[0]  = '0;
    quo_q[0]  = '0;
    tag_q[0]  = tag_i;
  end

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [RW:0] sh;
    logic        ge;
    assign sh = {rem_q[s], (s == 0) ? 1'b1 : 1'b0};
    assign ge = sh >= {2'b0, dm_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dm_q[s+1]   <= dm_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
        tag_q[s+1]  <= tag_q[s];
        rem_q[s+1]  <= ge ? RW'(sh - {2'b0, dm_q[s]}) : RW'(sh);
        quo_q[s+1]  <= {quo_q[s][N-2:0], ge};
      end
    end
  end

  logic [W-1:0] qs;
  always_comb begin
    if (N > W - 1 && quo_q[N][N-1 -: ((N > W-1) ? (N-W+1) : 1)] != '0) begin
      qs = {1'b0, {(W-1){1'b1}}};
    end else if (N >= W && quo_q[N][W-1]) begin
      qs = {1'b0, {(W-1){1'b1}}};
    end else begin
      qs = W'(quo_q[N]);
    end
    if (zero_q[N]) begin
      r_o = {1'b0, {(W-1){1'b1}}};
    end else if (neg_q[N]) begin
      r_o = ~qs + 1'b1;
    end else begin
      r_o = qs;
    end
  end
  assign tag_o = tag_q[N];

endmodule

// File: design/rbsi_front.sv
// Front end: forms saturated corner differences and the direction reciprocals.
module rbsi_front #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] box_min_i [3],
  input  logic [W-1:0] box_max_i [3],
  input  logic [W-1:0] org_i [3],
  input  logic [W-1:0] dir_i [3],
  input  logic [W-1:0] tn_i,
  input  logic [W-1:0] tf_i,
  output logic         vld_o,
  output logic [W-1:0] dmin_o [3],
  output logic [W-1:0] dmax_o [3],
  output logic [W-1:0] rcp_o [3],
  output logic [W-1:0] tn_o,
  output logic [W-1:0] tf_o
);
  import rbsi_pkg::*;

  localparam int unsigned N    = 2 * F + 1;
  localparam int unsigned TAGW = 4 * W + 1;

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] r;
    r = {a[W-1], a} - {b[W-1], b};
    if (r[W] != r[W-1]) begin
      sat_sub = r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat_sub = r[W-1:0];
    end
  endfunction

  logic [TAGW-1:0] tag_in [3];
  logic [TAGW-1:0] tag_out[3];

  for (genvar a = 0; a < 3; a++) begin : g_ax
    if (a == 0) begin : g_t0
      assign tag_in[a] = {vld_i, tn_i, tf_i, sat_sub(box_min_i[a], org_i[a]),
                          sat_sub(box_max_i[a], org_i[a])};
    end else begin : g_tn
      assign tag_in[a] = {1'b0, {(2*W){1'b0}}, sat_sub(box_min_i[a], org_i[a]),
                          sat_sub(box_max_i[a], org_i[a])};
    end
    rbsi_sdiv #(.W(W), .F(F), .TAGW(TAGW)) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .d_i   (dir_i[a]),
      .tag_i (tag_in[a]),
      .r_o   (rcp_o[a]),
      .tag_o (tag_out[a])
    );
    assign dmin_o[a] = tag_out[a][2*W-1:W];
    assign dmax_o[a] = tag_out[a][W-1:0];
  end

  // Valid bits ride a reset pipeline so that garbage never leaves after reset.
  logic [N-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], vld_i};
    end
  end
  assign vld_o = vld_q[N-1];
  assign tn_o  = tag_out[0][4*W-1:3*W];
  assign tf_o  = tag_out[0][3*W-1:2*W];

endmodule

// File: design/rbsi_back.sv
// Back end: slab products, interval intersection and result selection.
module rbsi_back #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] dmin_i [3],
  input  logic [W-1:0] dmax_i [3],
  input  logic [W-1:0] rcp_i [3],
  input  logic [W-1:0] tn_i,
  input  logic [W-1:0] tf_i,
  output logic         vld_o,
  output logic         hit_o,
  output logic [W-1:0] dist_o
);
  import rbsi_pkg::*;

  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // Stage 1: magnitudes multiplied.
  logic [2*W-1:0] plo_q[3], phi_q[3];
  logic           nlo_q[3], nhi_q[3];
  logic [W-1:0]   tn1_q, tf1_q;

  function automatic logic [W-1:0] mg(input logic [W-1:0] v);
    mg = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W-1:0] scale(input logic [2*W-1:0] p, input logic n);
    logic [2*W-1:0] m;
    m = p >> F;
    if (m[2*W-1:W-1] != '0) begin
      if (n) scale = VMIN;
      else scale = VMAX;
    end else begin
      scale = n ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    end
  endfunction

  for (genvar a = 0; a < 3; a++) begin : g_mul
    logic [W-1:0] lo_op, hi_op;
    assign lo_op = rcp_i[a][W-1] ? dmax_i[a] : dmin_i[a];
    assign hi_op = rcp_i[a][W-1] ? dmin_i[a] : dmax_i[a];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[a] <= mg(lo_op) * mg(rcp_i[a]);
        phi_q[a] <= mg(hi_op) * mg(rcp_i[a]);
        nlo_q[a] <= lo_op[W-1] ^ rcp_i[a][W-1];
        nhi_q[a] <= hi_op[W-1] ^ rcp_i[a][W-1];
      end
    end
  end

  // Stage 2: scaled and saturated slab bounds.
  logic [W-1:0] lo2_q[3], hi2_q[3];
  logic [W-1:0] tn2_q, tf2_q;
  for (genvar a = 0; a < 3; a++) begin : g_sc
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo2_q[a] <= scale(plo_q[a], nlo_q[a]);
        hi2_q[a] <= scale(phi_q[a], nhi_q[a]);
      end
    end
  end

  // Stage 3: x and y slabs intersected.
  logic         ok3_q;
  logic [W-1:0] lo3_q, hi3_q, lz3_q, hz3_q, tn3_q, tf3_q;

  // Stage 4: z slab and the bounds decide.
  logic         hit_q;
  logic [W-1:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tn1_q <= tn_i;
      tf1_q <= tf_i;
      tn2_q <= tn1_q;
      tf2_q <= tf1_q;
      ok3_q <= !($signed(lo2_q[0]) > $signed(hi2_q[1]) ||
                 $signed(lo2_q[1]) > $signed(hi2_q[0]));
      lo3_q <= ($signed(lo2_q[1]) > $signed(lo2_q[0])) ? lo2_q[1] : lo2_q[0];
      hi3_q <= ($signed(hi2_q[1]) < $signed(hi2_q[0])) ? hi2_q[1] : hi2_q[0];
      lz3_q <= lo2_q[2];
      hz3_q <= hi2_q[2];
      tn3_q <= tn2_q;
      tf3_q <= tf2_q;
    end
  end

  logic         h4;
  logic [W-1:0] l4, u4;
  always_comb begin
    l4 = ($signed(lz3_q) > $signed(lo3_q)) ? lz3_q : lo3_q;
    u4 = ($signed(hz3_q) < $signed(hi3_q)) ? hz3_q : hi3_q;
    h4 = ok3_q && !($signed(lo3_q) > $signed(hz3_q) || $signed(lz3_q) > $signed(hi3_q))
         && !($signed(l4) > $signed(tf3_q) || $signed(u4) < $signed(tn3_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= h4;
      dist_q <= !h4 ? VMAX : (($signed(u4) < $signed(tf3_q)) ? u4 : tf3_q);
    end
  end

  logic [3:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o  = vld_q[3];
  assign hit_o  = hit_q;
  assign dist_o = dist_q;

endmodule

// File: design/rbsi_queue.sv
// Short queue parting the front pipeline from the back pipeline.
module rbsi_queue #(
  parameter int unsigned DW = 33,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o,
  output logic          room_o
);
  import rbsi_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign room_o  = cnt_q != (AW+1)'(DEPTH);

endmodule
